/* hw/rtl/lta_pkg.sv */
// Shared types and constants for the lottery arbiter.
package lta_pkg;

  localparam int KIND_W   = 3;
  localparam int ENTRY_W  = 4;
  localparam int AMOUNT_W = 16;
  localparam int RAND_W   = 32;
  localparam int WINNER_W = 4;
  localparam int DIV_CNT_W = $clog2(RAND_W);

  typedef enum logic [KIND_W-1:0] {
    OP_ATTACH    = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_SET_READY = 3'd2,
    OP_TRANSFER  = 3'd3,
    OP_DRAW      = 3'd4
  } op_e_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_XFER_SRC,
    ST_XFER_DST,
    ST_SUM,
    ST_SUM_END,
    ST_CHECK,
    ST_DIV,
    ST_PICK,
    ST_PICK_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic xfer_rd;
    logic xfer_src;
    logic xfer_dst;
    logic walk_start;
    logic walk_rd;
    logic pick;
    logic div_init;
    logic div_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              xfer_ok;
    logic              walk_last;
    logic              total_zero;
    logic              div_last;
    logic              res_busy;
  } sts_t;

endpackage

/* hw/rtl/lottery_arbiter_top.sv */
// Lottery arbiter top level: sequencer plus datapath.
// Attach, release, set ready, unused kinds and refused transfers go from decode to the
// result; a transfer writes source then destination; a draw makes two table walks around
// a 32-step remainder unit, or one walk when no ticket is eligible. One word in flight:
// the next is taken the cycle after the result is loaded, even while it waits on rsp_ready.
// Reset (synchronous, rst high) clears all valid and ready marks, so the table reads as empty.
module lottery_arbiter_top #(
  parameter int ENTRIES     = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [lta_pkg::KIND_W-1:0]   kind,
  input  logic [lta_pkg::ENTRY_W-1:0]  entry,
  input  logic [lta_pkg::ENTRY_W-1:0]  other_entry,
  input  logic [lta_pkg::AMOUNT_W-1:0] amount,
  input  logic                         use_default,
  input  logic                         ready_flag,
  input  logic [lta_pkg::RAND_W-1:0]   random_value,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic                         granted,
  output logic [lta_pkg::WINNER_W-1:0] winner,
  output logic [lta_pkg::AMOUNT_W-1:0] moved
);

  lta_pkg::cmd_t cmd;
  lta_pkg::sts_t sts;

  lta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lta_dp #(
    .ENTRIES     (ENTRIES),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .entry        (entry),
    .other_entry  (other_entry),
    .amount       (amount),
    .use_default  (use_default),
    .ready_flag   (ready_flag),
    .random_value (random_value),
    .cmd          (cmd),
    .sts          (sts),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .granted      (granted),
    .winner       (winner),
    .moved        (moved)
  );

endmodule

/* hw/rtl/lta_ctrl.sv */
// Sequencer for the lottery arbiter: decodes each word and steps the datapath.
module lta_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lta_pkg::sts_t sts,
  output lta_pkg::cmd_t cmd
);

  lta_pkg::state_t state;
  lta_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lta_pkg::ST_IDLE: begin
        if (req_valid) state_next = lta_pkg::ST_DECODE;
      end
      lta_pkg::ST_DECODE: begin
        unique case (sts.kind)
          lta_pkg::OP_TRANSFER: begin
            state_next = sts.xfer_ok ? lta_pkg::ST_XFER_SRC : lta_pkg::ST_DONE;
          end
          lta_pkg::OP_DRAW: state_next = lta_pkg::ST_SUM;
          default:          state_next = lta_pkg::ST_DONE;
        endcase
      end
      lta_pkg::ST_XFER_SRC: state_next = lta_pkg::ST_XFER_DST;
      lta_pkg::ST_XFER_DST: state_next = lta_pkg::ST_DONE;
      lta_pkg::ST_SUM: begin
        if (sts.walk_last) state_next = lta_pkg::ST_SUM_END;
      end
      lta_pkg::ST_SUM_END: state_next = lta_pkg::ST_CHECK;
      lta_pkg::ST_CHECK: begin
        state_next = sts.total_zero ? lta_pkg::ST_DONE : lta_pkg::ST_DIV;
      end
      lta_pkg::ST_DIV: begin
        if (sts.div_last) state_next = lta_pkg::ST_PICK;
      end
      lta_pkg::ST_PICK: begin
        if (sts.walk_last) state_next = lta_pkg::ST_PICK_END;
      end
      lta_pkg::ST_PICK_END: state_next = lta_pkg::ST_DONE;
      lta_pkg::ST_DONE: begin
        if (!sts.res_busy) state_next = lta_pkg::ST_IDLE;
      end
      default: state_next = lta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      lta_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      lta_pkg::ST_DECODE: begin
        unique case (sts.kind)
          lta_pkg::OP_ATTACH, lta_pkg::OP_RELEASE, lta_pkg::OP_SET_READY: begin
            cmd.apply = 1'b1;
          end
          lta_pkg::OP_TRANSFER: cmd.xfer_rd    = sts.xfer_ok;
          lta_pkg::OP_DRAW:     cmd.walk_start = 1'b1;
          default: ;
        endcase
      end
      lta_pkg::ST_XFER_SRC: cmd.xfer_src = 1'b1;
      lta_pkg::ST_XFER_DST: cmd.xfer_dst = 1'b1;
      lta_pkg::ST_SUM:      cmd.walk_rd  = 1'b1;
      lta_pkg::ST_CHECK: begin
        cmd.walk_start = 1'b1;
        cmd.div_init   = 1'b1;
      end
      lta_pkg::ST_DIV: cmd.div_step = 1'b1;
      lta_pkg::ST_PICK: begin
        cmd.walk_rd = 1'b1;
        cmd.pick    = 1'b1;
      end
      lta_pkg::ST_DONE: cmd.res_load = !sts.res_busy;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/lta_dp.sv */
// Datapath: ticket table, entry marks, walk accumulator, divider and result register.
module lta_dp #(
  parameter int ENTRIES     = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lta_pkg::KIND_W-1:0]     kind,
  input  logic [lta_pkg::ENTRY_W-1:0]    entry,
  input  logic [lta_pkg::ENTRY_W-1:0]    other_entry,
  input  logic [lta_pkg::AMOUNT_W-1:0]   amount,
  input  logic                           use_default,
  input  logic                           ready_flag,
  input  logic [lta_pkg::RAND_W-1:0]     random_value,
  input  lta_pkg::cmd_t                  cmd,
  output lta_pkg::sts_t                  sts,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           granted,
  output logic [lta_pkg::WINNER_W-1:0]   winner,
  output logic [lta_pkg::AMOUNT_W-1:0]   moved
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int TOT_W = TICKET_BITS + IDX_W;
  localparam logic [TICKET_BITS-1:0] TMAX = '1;

  // latched word
  logic [lta_pkg::KIND_W-1:0]   kind_q;
  logic [lta_pkg::ENTRY_W-1:0]  e_q;
  logic [lta_pkg::ENTRY_W-1:0]  o_q;
  logic [lta_pkg::AMOUNT_W-1:0] amount_q;
  logic                         use_def_q;
  logic                         rdy_q;

  logic [IDX_W-1:0] e_idx;
  logic [IDX_W-1:0] o_idx;
  logic             e_ok;
  logic             o_ok;

  // ticket table and marks
  logic [TICKET_BITS-1:0] cnt_mem [ENTRIES];
  logic [ENTRIES-1:0]     valid_r;
  logic [ENTRIES-1:0]     ready_r;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [TICKET_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_a_addr;
  logic [TICKET_BITS-1:0] rd_a_data;
  logic [TICKET_BITS-1:0] rd_b_data;

  // transfer
  logic [31:0]                  n32;
  logic [TICKET_BITS-1:0]       attach_cnt;
  logic [lta_pkg::AMOUNT_W-1:0] take;
  logic [TICKET_BITS-1:0]       src_new;
  logic [TICKET_BITS-1:0]       src_new_q;
  logic [lta_pkg::AMOUNT_W-1:0] moved_q;
  logic [TICKET_BITS-1:0]       dst_base;
  logic [TICKET_BITS:0]         dst_sum;
  logic [TICKET_BITS-1:0]       dst_new;

  // walk
  logic [IDX_W-1:0] walk_idx;
  logic             pipe_vld;
  logic             pipe_pick;
  logic [IDX_W-1:0] pipe_idx;
  logic             elig;
  logic [TOT_W-1:0] acc;
  logic [TOT_W-1:0] acc_sum;
  logic             found;
  logic             hit;
  logic [IDX_W-1:0] win_idx;

  // divider
  logic [TOT_W-1:0]              total;
  logic [TOT_W-1:0]              rem;
  logic [TOT_W:0]                r2;
  logic [lta_pkg::RAND_W-1:0]    dvd;
  logic [lta_pkg::DIV_CNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q    <= kind;
      e_q       <= entry;
      o_q       <= other_entry;
      amount_q  <= amount;
      use_def_q <= use_default;
      rdy_q     <= ready_flag;
      dvd       <= random_value;
    end else if (cmd.div_step) begin
      dvd <= dvd << 1;
    end
  end

  assign e_idx = IDX_W'(e_q);
  assign o_idx = IDX_W'(o_q);
  assign e_ok  = 32'(e_q) < ENTRIES;
  assign o_ok  = 32'(o_q) < ENTRIES;

  // attach count, saturated to the ticket width
  assign n32        = use_def_q ? 32'd1 : 32'(amount_q);
  assign attach_cnt = (n32 > 32'(TMAX)) ? TMAX : TICKET_BITS'(n32);

  assign take    = (32'(amount_q) > 32'(rd_a_data)) ? lta_pkg::AMOUNT_W'(rd_a_data) : amount_q;
  assign src_new = rd_a_data - TICKET_BITS'(take);
  // a self transfer must add back onto the freshly lowered count
  assign dst_base = (o_q == e_q) ? src_new_q : rd_b_data;
  assign dst_sum  = {1'b0, dst_base} + (TICKET_BITS + 1)'(moved_q);
  assign dst_new  = dst_sum[TICKET_BITS] ? TMAX : dst_sum[TICKET_BITS-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = e_idx;
    wr_data = '0;
    if (cmd.apply && e_ok) begin
      case (kind_q)
        lta_pkg::OP_ATTACH: begin
          wr_en   = 1'b1;
          wr_data = attach_cnt;
        end
        lta_pkg::OP_RELEASE: wr_en = 1'b1;
        default: ;
      endcase
    end
    if (cmd.xfer_src) begin
      wr_en   = 1'b1;
      wr_data = src_new;
    end
    if (cmd.xfer_dst) begin
      wr_en   = 1'b1;
      wr_addr = o_idx;
      wr_data = dst_new;
    end
  end

  assign rd_en     = cmd.xfer_rd | cmd.walk_rd;
  assign rd_a_addr = cmd.walk_rd ? walk_idx : e_idx;

  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_a_data <= cnt_mem[rd_a_addr];
      rd_b_data <= cnt_mem[o_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= '0;
      ready_r <= '0;
    end else if (cmd.apply && e_ok) begin
      case (kind_q)
        lta_pkg::OP_ATTACH:    valid_r[e_idx] <= 1'b1;
        lta_pkg::OP_RELEASE: begin
          valid_r[e_idx] <= 1'b0;
          ready_r[e_idx] <= 1'b0;
        end
        lta_pkg::OP_SET_READY: ready_r[e_idx] <= rdy_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      moved_q <= '0;
    end else if (cmd.xfer_src) begin
      moved_q   <= take;
      src_new_q <= src_new;
    end
  end

  // walk: read issued one cycle, counted the next
  assign elig    = pipe_vld && valid_r[pipe_idx] && ready_r[pipe_idx];
  assign acc_sum = acc + (elig ? TOT_W'(rd_a_data) : '0);
  assign hit     = elig && pipe_pick && !found && (acc_sum > rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.walk_rd;
    end
  end

  always_ff @(posedge clk) begin
    pipe_pick <= cmd.pick;
    pipe_idx  <= walk_idx;
    if (cmd.walk_start) begin
      walk_idx <= '0;
      acc      <= '0;
    end else begin
      if (cmd.walk_rd) walk_idx <= walk_idx + 1'b1;
      if (pipe_vld)    acc      <= acc_sum;
    end
    if (cmd.load) begin
      found   <= 1'b0;
      win_idx <= '0;
    end else if (hit) begin
      found   <= 1'b1;
      win_idx <= pipe_idx;
    end
  end

  // restoring remainder, one dividend bit per step
  assign r2 = {rem, dvd[lta_pkg::RAND_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      total   <= acc;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (r2 >= {1'b0, total}) begin
        rem <= TOT_W'(r2 - {1'b0, total});
      end else begin
        rem <= r2[TOT_W-1:0];
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      granted <= found;
      winner  <= lta_pkg::WINNER_W'(win_idx);
      moved   <= moved_q;
    end
  end

  always_comb begin
    sts            = '0;
    sts.kind       = kind_q;
    sts.xfer_ok    = e_ok && o_ok && (amount_q != '0) && valid_r[e_idx] && valid_r[o_idx];
    sts.walk_last  = walk_idx == IDX_W'(ENTRIES - 1);
    sts.total_zero = acc == '0;
    sts.div_last   = div_cnt == '1;
    sts.res_busy   = rsp_valid && !rsp_ready;
  end

endmodule
